FILE: hw/rtl/vec_pkg.sv
// Shared constants, register codes and queue entry type for the vertical edge filter.
package vec_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_W_BITS = 12;
    localparam int CFG_H_BITS = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_W_BITS-1:0] WIDTH_RST  = 12'd256;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RST = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 10;
    localparam int DIFF_W = 11;
    localparam int MAG_W  = 10;

    // floor(x * 911 / 8192) == floor(x / 9) for 0 <= x <= 765
    localparam logic [MAG_W-1:0] DIV9_MUL = 10'd911;
    localparam int DIV9_SHIFT = 13;
    localparam int PROD_W     = 20;
    localparam int QUO_W      = PROD_W - DIV9_SHIFT;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic                     last;
    } t_qent;

endpackage

FILE: hw/rtl/vec_front.sv
// Front end: raster counters, line stores, 3x3 window and column difference.
module vec_front #(
    parameter int MAX_WIDTH  = vec_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = vec_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(MAX_WIDTH):0]       i_eff_w,
    input  logic [$clog2(MAX_HEIGHT):0]      i_eff_h,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [vec_pkg::PIX_W-1:0]        i_gray_pixel,
    input  logic [vec_pkg::QCNT_W-1:0]       i_q_count,
    output logic                             o_push,
    output vec_pkg::t_qent                   o_push_ent
);
    import vec_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W:0]   col_p1;
    logic [ROW_W:0]   row_p1;
    logic             acc;
    logic             hit;
    logic             last;

    logic             r_a_vld;
    logic [PIX_W-1:0] r_a_pix;
    logic [COL_W-1:0] r_a_col;
    logic             r_a_hit;
    logic             r_a_last;
    logic             r_byp;
    logic [PIX_W-1:0] r_byp_top;
    logic [PIX_W-1:0] r_byp_mid;
    logic [PIX_W-1:0] r_rd_top;
    logic [PIX_W-1:0] r_rd_mid;
    logic [PIX_W-1:0] a_top;
    logic [PIX_W-1:0] a_mid;

    logic [PIX_W-1:0] r_line_top [MAX_WIDTH];
    logic [PIX_W-1:0] r_line_mid [MAX_WIDTH];
    logic [PIX_W-1:0] r_win [6];

    logic [SUM_W-1:0]         left_sum;
    logic [SUM_W-1:0]         right_sum;
    logic signed [DIFF_W-1:0] diff;

    assign o_in_ready = i_rst_n &&
        (((QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(r_a_vld)) < (QCNT_W+1)'(QDEPTH));
    assign acc = i_in_valid && o_in_ready;

    assign col_p1 = {1'b0, r_col} + (COL_W+1)'(1);
    assign row_p1 = {1'b0, r_row} + (ROW_W+1)'(1);

    assign hit  = ({1'b0, r_col} < i_eff_w) && ({1'b0, r_row} < i_eff_h) &&
                  (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
    assign last = (col_p1 == i_eff_w) && (row_p1 == i_eff_h);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_p1 >= i_eff_w) begin
            n_col = '0;
            n_row = (row_p1 >= i_eff_h) ? '0 : row_p1[ROW_W-1:0];
        end else begin
            n_col = col_p1[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= acc;
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // forward the previous item's write when it targets the same column
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_pix   <= i_gray_pixel;
            r_a_col   <= r_col;
            r_a_hit   <= hit;
            r_a_last  <= last;
            r_byp     <= r_a_vld && (r_a_col == r_col);
            r_byp_top <= a_mid;
            r_byp_mid <= r_a_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_top <= r_line_top[r_col];
            r_rd_mid <= r_line_mid[r_col];
        end
        if (r_a_vld) begin
            r_line_top[r_a_col] <= a_mid;
            r_line_mid[r_a_col] <= r_a_pix;
        end
    end

    assign a_top = r_byp ? r_byp_top : r_rd_top;
    assign a_mid = r_byp ? r_byp_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_a_vld) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= a_top;
            r_win[4] <= a_mid;
            r_win[5] <= r_a_pix;
        end
    end

    assign left_sum  = SUM_W'(r_win[0]) + SUM_W'(r_win[1]) + SUM_W'(r_win[2]);
    assign right_sum = SUM_W'(a_top) + SUM_W'(a_mid) + SUM_W'(r_a_pix);
    assign diff      = signed'({1'b0, left_sum}) - signed'({1'b0, right_sum});

    assign o_push          = r_a_vld && r_a_hit;
    assign o_push_ent.diff = diff;
    assign o_push_ent.last = r_a_last;

endmodule

FILE: hw/rtl/vec_queue.sv
// Short FIFO of column differences between the front end and the divider.
module vec_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  vec_pkg::t_qent              i_push_ent,
    input  logic                        i_pop,
    output logic                        o_valid,
    output vec_pkg::t_qent              o_ent,
    output logic [vec_pkg::QCNT_W-1:0]  o_count
);
    import vec_pkg::*;

    t_qent              r_buf [QDEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QCNT_W-1:0]  n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_buf[r_rp];
    assign o_count = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_push_ent;
        end
    end

endmodule

FILE: hw/rtl/vec_back.sv
// Back end: signed divide by nine by reciprocal multiply, and the output register.
module vec_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  vec_pkg::t_qent              i_q_ent,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [vec_pkg::PIX_W-1:0]   o_edge_value,
    output logic                        o_frame_done
);
    import vec_pkg::*;

    logic              o_adv;
    logic              m_adv;
    logic [DIFF_W-1:0] neg_diff;
    logic [MAG_W-1:0]  mag;

    logic              r_m_vld;
    logic [PROD_W-1:0] r_m_prod;
    logic              r_m_neg;
    logic              r_m_last;

    logic [QUO_W-1:0]  quo;
    logic [PIX_W-1:0]  n_edge;

    logic              r_o_vld;
    logic [PIX_W-1:0]  r_o_edge;
    logic              r_o_last;

    assign o_adv = !r_o_vld || i_out_ready;
    assign m_adv = !r_m_vld || o_adv;
    assign o_pop = i_q_valid && m_adv;

    assign neg_diff = DIFF_W'(0) - i_q_ent.diff;
    assign mag      = i_q_ent.diff[DIFF_W-1] ? neg_diff[MAG_W-1:0]
                                             : i_q_ent.diff[MAG_W-1:0];

    assign quo    = r_m_prod[PROD_W-1:DIV9_SHIFT];
    assign n_edge = r_m_neg ? (PIX_W'(0) - PIX_W'(quo)) : PIX_W'(quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (m_adv) begin
                r_m_vld <= i_q_valid;
            end
            if (o_adv) begin
                r_o_vld <= r_m_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_prod <= PROD_W'(mag) * PROD_W'(DIV9_MUL);
            r_m_neg  <= i_q_ent.diff[DIFF_W-1];
            r_m_last <= i_q_ent.last;
        end
        if (o_adv && r_m_vld) begin
            r_o_edge <= n_edge;
            r_o_last <= r_m_last;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_edge_value = r_o_edge;
    assign o_frame_done = r_o_last;

endmodule

FILE: hw/rtl/vertical_edge_conv_3x3_top.sv
// Top level of the 3x3 vertical edge filter over a raster grayscale stream.
//
// Input channel: i_in_valid / o_in_ready carry one gray pixel per item in
// raster order. Output channel: o_out_valid / i_out_ready carry one edge byte
// per complete 3x3 window, with o_frame_done set on the last window of a frame.
// Pixels in the first two rows or columns, or outside the programmed size,
// give no output item.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 image width, 1 image height). The user must write only while the block
// is idle; the block itself does not enforce this. Throughput: one pixel
// per cycle while the receiver does not stall. From pixel accept to its
// output item, a pixel passes the line store read, the window and column
// difference into the queue, the reciprocal multiply and the output register.
// A four-entry queue sits between the window front end and the divider. When
// the receiver stalls, the back end holds its items, the queue fills and
// o_in_ready drops once the queue and the in-flight window stage reach four.
// Reset clears counters, window, queue and output; width and height return to
// 256. Line stores are not cleared and are filled by the first two rows.
module vertical_edge_conv_3x3_top #(
    parameter int MAX_WIDTH  = vec_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = vec_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vec_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vec_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [vec_pkg::PIX_W-1:0]        i_gray_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [vec_pkg::PIX_W-1:0]        o_edge_value,
    output logic                             o_frame_done
);
    import vec_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SATW_W = (CFG_W_BITS > COL_W + 1) ? CFG_W_BITS : COL_W + 1;
    localparam int SATH_W = (CFG_H_BITS > ROW_W + 1) ? CFG_H_BITS : ROW_W + 1;

    logic [CFG_W_BITS-1:0] r_img_w;
    logic [CFG_H_BITS-1:0] r_img_h;
    logic [SATW_W-1:0]     w_ext;
    logic [SATH_W-1:0]     h_ext;
    logic [COL_W:0]        eff_w;
    logic [ROW_W:0]        eff_h;

    logic                  push;
    t_qent                 push_ent;
    logic                  pop;
    logic                  q_valid;
    t_qent                 q_ent;
    logic [QCNT_W-1:0]     q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_RST;
            r_img_h <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[CFG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // saturate to the line store size, zero acts as one
    always_comb begin
        w_ext = SATW_W'(r_img_w);
        h_ext = SATH_W'(r_img_h);
        if (w_ext == '0) begin
            eff_w = (COL_W+1)'(1);
        end else if (w_ext > SATW_W'(MAX_WIDTH)) begin
            eff_w = (COL_W+1)'(MAX_WIDTH);
        end else begin
            eff_w = (COL_W+1)'(w_ext);
        end
        if (h_ext == '0) begin
            eff_h = (ROW_W+1)'(1);
        end else if (h_ext > SATH_W'(MAX_HEIGHT)) begin
            eff_h = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            eff_h = (ROW_W+1)'(h_ext);
        end
    end

    vec_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_eff_w      (eff_w),
        .i_eff_h      (eff_h),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_gray_pixel (i_gray_pixel),
        .i_q_count    (q_count),
        .o_push       (push),
        .o_push_ent   (push_ent)
    );

    vec_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_ent      (q_ent),
        .o_count    (q_count)
    );

    vec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_ent      (q_ent),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_edge_value (o_edge_value),
        .o_frame_done (o_frame_done)
    );

endmodule

FILE: hw/rtl/vec_chk.sv
// Port-level checker for the vertical edge filter, bound to the top level.
module vec_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [vec_pkg::PIX_W-1:0]     o_edge_value,
    input logic                          o_frame_done
);
    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> $stable(o_edge_value) && $stable(o_frame_done))
        else $error("output payload changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3) &&
         !$past(in_acc, 4) && !$past(in_acc, 5) &&
         !o_out_valid && !$past(o_out_valid, 1) && !$past(o_out_valid, 2) &&
         !$past(o_out_valid, 3) && !$past(o_out_valid, 4))
        |-> o_in_ready)
        else $error("input not ready after pipeline drained");

endmodule

bind vertical_edge_conv_3x3_top vec_chk u_vec_chk (.*);
